// File: rtl/tpbb_pkg.sv
`default_nettype none

package tpbb_pkg;

    // Fixed-point formats: coordinates Q16.16, coefficients Q2.14 at these widths.
    localparam int COORD_BITS = 32;
    localparam int COEFF_BITS = 16;
    localparam int COEFF_FRAC = COEFF_BITS - 2;
    localparam int N_AXES     = 3;

    // Configuration port geometry.
    localparam int CFG_DATA_BITS = 64;
    localparam int CFG_IDX_BITS  = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_X = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_Y = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_Z = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OFS_X = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OFS_Y = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OFS_Z = 3'd5;

    // One input word: a point and the end-of-set flag.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic signed [COORD_BITS-1:0] point_z;
        logic                         last_point;
    } t_point;

    // A box: per-axis bounds. Used for the running box and for the result word.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] min_x;
        logic signed [COORD_BITS-1:0] max_x;
        logic signed [COORD_BITS-1:0] min_y;
        logic signed [COORD_BITS-1:0] max_y;
        logic signed [COORD_BITS-1:0] min_z;
        logic signed [COORD_BITS-1:0] max_z;
    } t_box;

    // One row of the linear part; element k multiplies input axis k.
    typedef logic [N_AXES-1:0][COEFF_BITS-1:0] t_coef_row;

    localparam int ROW_BITS = $bits(t_coef_row);

    // The whole transform as seen by the back end.
    typedef struct packed {
        t_coef_row [N_AXES-1:0]                 rows;
        logic      [N_AXES-1:0][COORD_BITS-1:0] offs;
    } t_xform;

endpackage

`default_nettype wire

// File: rtl/transformed_point_bounding_box_top.sv
// Transformed bounding box of a point set. Points (Q16.16) arrive one word per cycle with a
// flag on the last point of each set; the front end keeps a running per-axis minimum and
// maximum and takes a new point every cycle while the two-entry box queue has room. Each
// closed box goes to the back end, which maps it through the configured affine transform
// (Q2.14 coefficients plus offset) with a single shared multiplier: three multiply and
// accumulate steps plus one finish step per output, six outputs. The result word is
// registered and held until taken. Per box the back end takes the box, runs the transform
// and hands the result word over; it takes no new box until the result word is taken.
// Short sets are limited by the back end; longer ones run at one point per cycle while the
// queue has room. Configuration registers are written through the cfg port, which is
// always ready; write them only while the block is idle. Stall on the point input rises
// while the queue is full.
`default_nettype none

module transformed_point_bounding_box_top
    import tpbb_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire t_point                   i_point,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output t_box                          o_box,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam logic [COEFF_BITS-1:0] COEFF_ONE = COEFF_BITS'(1) << COEFF_FRAC;
    localparam int Q_DEPTH = 2;

    // Identity rows: 1.0 on the row's own axis, zero elsewhere.
    localparam t_coef_row ROW_X_ONE = t_coef_row'({{(2*COEFF_BITS){1'b0}}, COEFF_ONE});
    localparam t_coef_row ROW_Y_ONE =
        t_coef_row'({{COEFF_BITS{1'b0}}, COEFF_ONE, {COEFF_BITS{1'b0}}});
    localparam t_coef_row ROW_Z_ONE = t_coef_row'({COEFF_ONE, {(2*COEFF_BITS){1'b0}}});
    localparam t_xform XFORM_RESET =
        t_xform'({ROW_Z_ONE, ROW_Y_ONE, ROW_X_ONE, {(N_AXES*COORD_BITS){1'b0}}});

    t_xform              r_xform;
    logic [ROW_BITS-1:0] w_row_wdata;
    logic                w_cfg_we;
    logic                w_q_full;
    logic                w_push;
    t_box                w_push_box;
    logic                w_q_avail;
    logic                w_pop;
    t_box                w_head;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    // Coefficient bits past the data port read as zero.
    generate
        if (ROW_BITS <= CFG_DATA_BITS) begin : g_row_narrow
            assign w_row_wdata = i_cfg_data[ROW_BITS-1:0];
        end else begin : g_row_wide
            assign w_row_wdata = {{(ROW_BITS-CFG_DATA_BITS){1'b0}}, i_cfg_data};
        end
    endgenerate

    // Configuration registers; reset gives the identity transform.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xform <= XFORM_RESET;
        end else if (w_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ROW_X: r_xform.rows[0] <= t_coef_row'(w_row_wdata);
                CFG_ROW_Y: r_xform.rows[1] <= t_coef_row'(w_row_wdata);
                CFG_ROW_Z: r_xform.rows[2] <= t_coef_row'(w_row_wdata);
                CFG_OFS_X: r_xform.offs[0] <= i_cfg_data[COORD_BITS-1:0];
                CFG_OFS_Y: r_xform.offs[1] <= i_cfg_data[COORD_BITS-1:0];
                CFG_OFS_Z: r_xform.offs[2] <= i_cfg_data[COORD_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Point intake and running bounds.
    tpbb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_point    (i_point),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_box      (w_push_box)
    );

    // Closed boxes waiting for the transform.
    tpbb_fifo #(
        .WIDTH ($bits(t_box)),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_box),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_avail (w_q_avail),
        .o_data  (w_head)
    );

    // Transform of the box corners and the result word register.
    tpbb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_xform     (r_xform),
        .i_avail     (w_q_avail),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_box       (o_box)
    );

endmodule

`default_nettype wire

// File: rtl/tpbb_fifo.sv
`default_nettype none

module tpbb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_avail,
    output logic      [WIDTH-1:0] o_data
);

    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr;
    logic [PTR_BITS-1:0] r_rd;
    logic [CNT_BITS-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_BITS'(DEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    // Storage is written only on a push; it needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |=> (r_cnt != '0))
        else $error("queue count lost while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_avail && !i_push) |=> !o_avail)
        else $error("queue became non-empty without a push");

    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop && !o_full) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count did not follow a push");

endmodule

`default_nettype wire

// File: rtl/tpbb_front.sv
`default_nettype none

module tpbb_front
    import tpbb_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_in_valid,
    output logic        o_in_stall,
    input  wire t_point i_point,
    input  wire logic   i_q_full,
    output logic        o_push,
    output t_box        o_box
);

    logic r_open;
    t_box r_bnd;
    t_box n_bnd;
    logic w_take;

    assign o_in_stall = i_q_full;
    assign w_take     = i_in_valid && !i_q_full;

    // The first point of a set seeds the bounds; later points widen them.
    always_comb begin
        if (!r_open) begin
            n_bnd.min_x = i_point.point_x;
            n_bnd.max_x = i_point.point_x;
            n_bnd.min_y = i_point.point_y;
            n_bnd.max_y = i_point.point_y;
            n_bnd.min_z = i_point.point_z;
            n_bnd.max_z = i_point.point_z;
        end else begin
            n_bnd.min_x = (i_point.point_x < r_bnd.min_x) ? i_point.point_x : r_bnd.min_x;
            n_bnd.max_x = (i_point.point_x > r_bnd.max_x) ? i_point.point_x : r_bnd.max_x;
            n_bnd.min_y = (i_point.point_y < r_bnd.min_y) ? i_point.point_y : r_bnd.min_y;
            n_bnd.max_y = (i_point.point_y > r_bnd.max_y) ? i_point.point_y : r_bnd.max_y;
            n_bnd.min_z = (i_point.point_z < r_bnd.min_z) ? i_point.point_z : r_bnd.min_z;
            n_bnd.max_z = (i_point.point_z > r_bnd.max_z) ? i_point.point_z : r_bnd.max_z;
        end
    end

    // A closing point hands the finished box to the queue.
    assign o_push = w_take && i_point.last_point;
    assign o_box  = n_bnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
        end else if (w_take) begin
            r_open <= !i_point.last_point;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_bnd <= n_bnd;
        end
    end

    a_open_after_inner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && !i_point.last_point) |=> r_open)
        else $error("set not marked open after an inner point");

    a_closed_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> !r_open)
        else $error("set still open after its last point");

    a_box_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open |-> (r_bnd.min_x <= r_bnd.max_x) && (r_bnd.min_y <= r_bnd.max_y)
                   && (r_bnd.min_z <= r_bnd.max_z))
        else $error("running box has min above max");

endmodule

`default_nettype wire

// File: rtl/tpbb_back.sv
`default_nettype none

module tpbb_back
    import tpbb_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_xform i_xform,
    input  wire logic   i_avail,
    input  wire t_box   i_head,
    output logic        o_pop,
    output logic        o_out_valid,
    input  wire logic   i_out_stall,
    output t_box        o_box
);

    localparam int PROD_BITS = COORD_BITS + COEFF_BITS;
    localparam int ACC_BITS  = PROD_BITS + 2;
    localparam int SUM_BITS  = ACC_BITS + 1;
    localparam logic [2:0] LAST_OUT  = 3'd5;
    localparam logic [1:0] LAST_TERM = 2'd2;
    localparam logic signed [SUM_BITS-1:0] SAT_HI =
        {{(SUM_BITS-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] SAT_LO =
        {{(SUM_BITS-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_FIN,
        S_OUT
    } t_state;

    t_state                       r_state;
    t_box                         r_box;
    t_box                         r_res;
    logic [2:0]                   r_j;
    logic [1:0]                   r_k;
    logic signed [PROD_BITS-1:0]  r_prod;
    logic signed [ACC_BITS-1:0]   r_acc;
    logic                         r_out_valid;

    logic [1:0]                   w_row;
    logic                         w_want_max;
    logic signed [COEFF_BITS-1:0] w_coef;
    logic signed [COORD_BITS-1:0] w_lo;
    logic signed [COORD_BITS-1:0] w_hi;
    logic signed [COORD_BITS-1:0] w_bnd;
    logic signed [PROD_BITS-1:0]  n_prod;
    logic signed [ACC_BITS-1:0]   w_sh;
    logic signed [SUM_BITS-1:0]   w_sum;
    logic signed [COORD_BITS-1:0] w_ofs;
    logic signed [COORD_BITS-1:0] w_sat;

    // Output j: row j/2, minimum on even j and maximum on odd j.
    assign w_row      = r_j[2:1];
    assign w_want_max = r_j[0];
    assign w_coef     = $signed(i_xform.rows[w_row][r_k]);
    assign w_ofs      = $signed(i_xform.offs[w_row]);

    // Bounds of the input axis for the current term.
    always_comb begin
        unique case (r_k)
            2'd0: begin
                w_lo = r_box.min_x;
                w_hi = r_box.max_x;
            end
            2'd1: begin
                w_lo = r_box.min_y;
                w_hi = r_box.max_y;
            end
            default: begin
                w_lo = r_box.min_z;
                w_hi = r_box.max_z;
            end
        endcase
    end

    // The coefficient sign picks the bound that pushes the sum the wanted way.
    assign w_bnd  = (w_want_max ^ w_coef[COEFF_BITS-1]) ? w_hi : w_lo;
    assign n_prod = w_coef * w_bnd;

    // Floor the exact sum, add the offset, then clamp to the coordinate range.
    assign w_sh  = r_acc >>> COEFF_FRAC;
    assign w_sum = $signed({w_sh[ACC_BITS-1], w_sh})
                 + $signed({{(SUM_BITS-COORD_BITS){w_ofs[COORD_BITS-1]}}, w_ofs});

    always_comb begin
        if (w_sum > SAT_HI) begin
            w_sat = SAT_HI[COORD_BITS-1:0];
        end else if (w_sum < SAT_LO) begin
            w_sat = SAT_LO[COORD_BITS-1:0];
        end else begin
            w_sat = w_sum[COORD_BITS-1:0];
        end
    end

    assign o_pop       = (r_state == S_IDLE) && i_avail;
    assign o_out_valid = r_out_valid;
    assign o_box       = r_res;

    // Sequencer: three multiply-accumulate steps and one finish step per output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_j         <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_avail) begin
                        r_j     <= '0;
                        r_k     <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_k == LAST_TERM) begin
                        r_k     <= '0;
                        r_state <= S_FIN;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_MUL;
                    end
                end
                S_FIN: begin
                    if (r_j == LAST_OUT) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_OUT;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_MUL;
                    end
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_box <= i_head;
            r_acc <= '0;
        end
        if (r_state == S_MUL) begin
            r_prod <= n_prod;
        end
        if (r_state == S_ACC) begin
            r_acc <= r_acc + $signed({{(ACC_BITS-PROD_BITS){r_prod[PROD_BITS-1]}}, r_prod});
        end
        if (r_state == S_FIN) begin
            r_acc <= '0;
            unique case (r_j)
                3'd0:    r_res.min_x <= w_sat;
                3'd1:    r_res.max_x <= w_sat;
                3'd2:    r_res.min_y <= w_sat;
                3'd3:    r_res.max_y <= w_sat;
                3'd4:    r_res.min_z <= w_sat;
                default: r_res.max_z <= w_sat;
            endcase
        end
    end

    a_pop_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == S_MUL) && (r_j == '0) && (r_k == '0))
        else $error("box taken without starting the transform");

    a_valid_only_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == S_OUT))
        else $error("result shown outside the output state");

    a_fin_after_terms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> (r_k == '0) && ($past(r_state) == S_ACC))
        else $error("finish step reached without all terms");

    a_out_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_j <= LAST_OUT)
        else $error("output index out of range");

endmodule

`default_nettype wire
